// File: hdl/ipsh_pkg.sv
// shared types, constants and helpers of the incremental pid block
package ipsh_pkg;

    localparam int NUM_W = 59;
    localparam int DEN_W = 40;
    localparam int QUO_W = 36;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHRINK   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd7;

    localparam int HALF_TURN = 2880;
    localparam int FULL_TURN = 5760;
    localparam logic [DEN_W-1:0] UNITY_Q24 = DEN_W'(1) << 24;

    typedef enum logic [3:0] {
        S_IDLE, S_FMUL, S_FUPD, S_ERR, S_WDIV, S_WFIX, S_PMUL, S_PADD,
        S_DMUL, S_DADD, S_NMUL, S_DENMUL, S_IDIVST, S_IDIV, S_IADD, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_FMUL, OP_FUPD, OP_ERR, OP_WSTEP, OP_WFIX, OP_PMUL,
        OP_PADD, OP_DMUL, OP_DADD, OP_NMUL, OP_DENMUL, OP_IADD, OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic wrap_needed;
        logic wrap_last;
        logic div_done;
    } t_sts;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607) begin
            r = 24'sh7fffff;
        end else if (v < -64'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/ipsh_in_if.sv
// input channel: one measurement and one gyro rate per transfer
interface ipsh_in_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] measurement;
    logic [W-1:0] gyro_rate;
    modport source(output valid, measurement, gyro_rate, input ready);
    modport sink(input valid, measurement, gyro_rate, output ready);
endinterface

// File: hdl/ipsh_out_if.sv
// output channel: drive value and saturation flag per transfer
interface ipsh_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] drive;
    logic        saturated;
    modport source(output valid, drive, saturated, input ready);
    modport sink(input valid, drive, saturated, output ready);
endinterface

// File: hdl/ipsh_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module ipsh_div #(
    parameter int N = 59,
    parameter int D = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quotient
);
    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  r_quo;
    logic [D-1:0]  r_rem;
    logic [D-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [D:0]    n_try;
    logic [D:0]    n_sub;

    assign n_try = {r_rem, r_quo[N-1]};
    assign n_sub = n_try - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (n_try >= {1'b0, r_den}) begin
                r_rem <= n_sub[D-1:0];
                r_quo <= {r_quo[N-2:0], 1'b1};
            end else begin
                r_rem <= n_try[D-1:0];
                r_quo <= {r_quo[N-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
`endif
endmodule

// File: hdl/ipsh_dp.sv
// datapath: config registers, filter, error, shared multiplier, accumulator
module ipsh_dp
    import ipsh_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [W-1:0]          i_measurement,
    input  logic [W-1:0]          i_gyro_rate,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [15:0]           o_drive,
    output logic                  o_saturated
);
    localparam int AW = (W + 9 > 26) ? W + 9 : 26;
    localparam int PW = AW + 17;
    localparam int SW = PW + 6;
    localparam int EW = ((W > 16) ? W : 16) + 1;
    localparam int KMAX = EW - 13;
    localparam int KW = $clog2(EW);

    logic              r_mode;
    logic signed [15:0] r_setpoint;
    logic [15:0]       r_gain_p, r_gain_i, r_gain_d, r_shrink;
    logic [8:0]        r_filter;
    logic [14:0]       r_limit;

    logic signed [W-1:0]  r_x, r_gyro;
    logic signed [23:0]   r_f, r_f1, r_f2, r_prev, r_err;
    logic signed [31:0]   r_acc;
    logic signed [SW-1:0] r_sum;
    logic signed [PW-1:0] r_prod;
    logic [NUM_W-1:0]     r_num;
    logic                 r_wneg;
    logic [EW-1:0]        r_wrem;
    logic [KW-1:0]        r_wk;
    logic [15:0]          r_drive;
    logic                 r_sat;

    logic signed [AW-1:0]   n_a;
    logic [15:0]            n_b;
    logic signed [PW-1:0]   n_prod;
    logic [8:0]             n_alpha;
    logic signed [EW-1:0]   n_e;
    logic [EW-1:0]          n_wmag;
    logic [EW-1:0]          n_wstep;
    logic                   n_wrap_hi, n_wrap_lo;
    logic [23:0]            n_mag;
    logic [NUM_W-1:0]       n_dividend;
    logic [DEN_W-1:0]       n_divisor;
    logic [NUM_W-1:0]       n_quo;
    logic                   n_div_done;
    logic signed [14:0]     n_wrapped;
    logic [12:0]            n_r;
    logic signed [SW-1:0]   n_q;
    logic signed [SW-1:0]   n_hi;
    logic signed [31:0]     n_clamped;
    logic                   n_sat;
    logic signed [31:0]     n_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_setpoint <= '0;
            r_gain_p   <= 16'd512;
            r_gain_i   <= 16'd26;
            r_gain_d   <= '0;
            r_shrink   <= 16'd2048;
            r_filter   <= 9'd77;
            r_limit    <= 15'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:     r_mode     <= i_cfg_data[0];
                REG_SETPOINT: r_setpoint <= i_cfg_data;
                REG_GAIN_P:   r_gain_p   <= i_cfg_data;
                REG_GAIN_I:   r_gain_i   <= i_cfg_data;
                REG_GAIN_D:   r_gain_d   <= i_cfg_data;
                REG_SHRINK:   r_shrink   <= i_cfg_data;
                REG_FILTER:   r_filter   <= i_cfg_data[8:0];
                REG_LIMIT:    r_limit    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign n_alpha = r_filter[8] ? 9'd256 : r_filter;
    assign n_mag   = r_err[23] ? 24'(-r_err) : 24'(r_err);

    // heading error before wrap and wrap detection
    assign n_e       = EW'(r_setpoint) - EW'(r_x);
    assign n_wrap_hi = n_e > EW'(HALF_TURN);
    assign n_wrap_lo = n_e < -EW'(HALF_TURN);
    always_comb begin
        if (n_wrap_hi) begin
            n_wmag = n_e - EW'(HALF_TURN + 1);
        end else begin
            n_wmag = -(n_e + EW'(HALF_TURN));
        end
    end

    // full-turn multiple for the current reduction step
    assign n_wstep = EW'(FULL_TURN) << r_wk;

    // shared multiplier operand select
    always_comb begin
        n_a = '0;
        n_b = '0;
        unique case (i_cmd.op)
            OP_FMUL: begin
                n_a = AW'((AW'(r_x) <<< 8) - AW'(r_f));
                n_b = 16'(n_alpha);
            end
            OP_PMUL: begin
                n_a = AW'(r_err) - AW'(r_prev);
                n_b = r_gain_p;
            end
            OP_DMUL: begin
                n_a = r_mode ? -AW'(r_gyro)
                             : AW'(r_f) - (AW'(r_f1) <<< 1) + AW'(r_f2);
                n_b = r_gain_d;
            end
            OP_NMUL: begin
                n_a = AW'({1'b0, n_mag});
                n_b = r_gain_i;
            end
            OP_DENMUL: begin
                n_a = AW'({1'b0, n_mag});
                n_b = r_shrink;
            end
            default: ;
        endcase
    end

    assign n_prod = PW'(n_a) * PW'($signed({1'b0, n_b}));

    assign n_dividend = r_num;
    assign n_divisor  = DEN_W'(r_prod) + UNITY_Q24;

    ipsh_div #(.N(NUM_W), .D(DEN_W)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (n_dividend),
        .i_divisor   (n_divisor),
        .o_done      (n_div_done),
        .o_quotient  (n_quo)
    );

    assign n_r = (r_wrem[12:0] == 13'd0) ? 13'd0 : 13'(FULL_TURN) - r_wrem[12:0];
    assign n_wrapped = r_wneg ? 15'($signed({2'b00, n_r})) - 15'sd2880
                              : 15'($signed({2'b00, r_wrem[12:0]})) - 15'sd2879;

    assign n_q = r_err[23] ? -SW'($signed({1'b0, n_quo[QUO_W-1:0]}))
                           : SW'($signed({1'b0, n_quo[QUO_W-1:0]}));

    // accumulator clamp
    assign n_hi = SW'($signed({1'b0, r_limit, 16'd0}));
    always_comb begin
        if (r_sum > n_hi) begin
            n_clamped = 32'(n_hi);
            n_sat     = 1'b1;
        end else if (r_sum < -n_hi) begin
            n_clamped = 32'(-n_hi);
            n_sat     = 1'b1;
        end else begin
            n_clamped = 32'(r_sum);
            n_sat     = 1'b0;
        end
    end
    assign n_neg = -n_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f    <= '0;
            r_f1   <= '0;
            r_f2   <= '0;
            r_prev <= '0;
            r_acc  <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_FUPD: r_f <= sat24(64'(PW'(r_f) + (r_prod >>> 8)));
                OP_FINISH: begin
                    r_acc  <= n_clamped;
                    r_prev <= r_err;
                    if (!r_mode) begin
                        r_f2 <= r_f1;
                        r_f1 <= r_f;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_x    <= i_measurement;
                r_gyro <= i_gyro_rate;
            end
            OP_FMUL, OP_PMUL, OP_DMUL, OP_NMUL: r_prod <= n_prod;
            OP_DENMUL: begin
                r_num  <= NUM_W'(r_prod) << 20;
                r_prod <= n_prod;
            end
            OP_ERR: begin
                if (!r_mode) begin
                    r_err <= sat24(64'((25'(r_setpoint) <<< 8) - 25'(r_f)));
                end else begin
                    r_wneg <= n_wrap_lo;
                    r_wrem <= n_wmag;
                    r_wk   <= KW'(KMAX);
                    r_err  <= 24'(n_e) <<< 8;
                end
            end
            OP_WSTEP: begin
                if (r_wrem >= n_wstep) begin
                    r_wrem <= r_wrem - n_wstep;
                end
                r_wk <= r_wk - KW'(1);
            end
            OP_WFIX: r_err <= 24'(n_wrapped) <<< 8;
            OP_PADD: r_sum <= SW'(r_acc) + SW'(r_prod >>> 4);
            OP_DADD: r_sum <= r_mode ? r_sum + (SW'(r_prod) <<< 4)
                                     : r_sum + SW'(r_prod >>> 4);
            OP_IADD: r_sum <= r_sum + n_q;
            OP_FINISH: begin
                r_sat   <= n_sat;
                r_drive <= n_clamped[31] ? 16'(-(n_neg >>> 16)) : n_clamped[31:16];
            end
            default: ;
        endcase
    end

    assign o_sts.wrap_needed = r_mode && (n_wrap_hi || n_wrap_lo);
    assign o_sts.wrap_last   = (r_wk == '0);
    assign o_sts.div_done    = n_div_done;
    assign o_drive           = r_drive;
    assign o_saturated       = r_sat;

`ifndef SYNTH
    a_acc_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.op == OP_FINISH) |->
            (r_acc <= $signed({1'b0, r_limit, 16'd0})
             && r_acc >= -$signed({1'b0, r_limit, 16'd0})))
        else $error("accumulator outside clamp range");
`endif
endmodule

// File: hdl/ipsh_ctrl.sv
// controller: sequences the datapath steps for one sample
module ipsh_ctrl
    import ipsh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.op == OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.op        = OP_NONE;
        o_cmd.div_start = 1'b0;
        o_in_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_FMUL;
                end
            end
            S_FMUL: begin
                o_cmd.op = OP_FMUL;
                n_state  = S_FUPD;
            end
            S_FUPD: begin
                o_cmd.op = OP_FUPD;
                n_state  = S_ERR;
            end
            S_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = i_sts.wrap_needed ? S_WDIV : S_PMUL;
            end
            S_WDIV: begin
                o_cmd.op = OP_WSTEP;
                if (i_sts.wrap_last) begin
                    n_state = S_WFIX;
                end
            end
            S_WFIX: begin
                o_cmd.op = OP_WFIX;
                n_state  = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.op = OP_PMUL;
                n_state  = S_PADD;
            end
            S_PADD: begin
                o_cmd.op = OP_PADD;
                n_state  = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.op = OP_DMUL;
                n_state  = S_DADD;
            end
            S_DADD: begin
                o_cmd.op = OP_DADD;
                n_state  = S_NMUL;
            end
            S_NMUL: begin
                o_cmd.op = OP_NMUL;
                n_state  = S_DENMUL;
            end
            S_DENMUL: begin
                o_cmd.op = OP_DENMUL;
                n_state  = S_IDIVST;
            end
            S_IDIVST: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_IDIV;
            end
            S_IDIV: begin
                if (i_sts.div_done) begin
                    n_state = S_IADD;
                end
            end
            S_IADD: begin
                o_cmd.op = OP_IADD;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_start_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> (r_state == S_IDIVST))
        else $error("division started outside its state");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == S_FMUL)
        else $error("accepted sample did not start the filter step");
    a_finish_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_FINISH) |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a pending transfer");
`endif
endmodule

// File: hdl/incremental_pid_speed_heading.sv
// top level of the incremental pid controller with speed and heading modes
//
// i_in carries one measurement and one gyro rate per transfer; o_out returns
// one drive value and a saturation flag for each accepted sample, in order.
// The user must write registers through i_cfg_we / i_cfg_idx / i_cfg_data
// only while the block is idle; the block itself does not enforce it. The
// registers: mode, setpoint, gains, integral shrink, filter weight, limit.
// A heading error outside one half turn adds 5 compare and subtract steps
// and a fix-up to the sequence of a sample. The serial divider of the
// variable integral term, one quotient bit per cycle, is the longest step
// of a sample. A single multiplier is shared by the filter, proportional,
// derivative and integral steps. A new sample is taken as soon as the
// previous result sits in the output register, so the datapath works on
// one sample at a time. Synchronous active-low reset restores the register
// defaults and clears the filter history, the previous error and the output
// accumulator. While the receiver stalls the pending result holds; the next
// sample is still processed and waits before its final step until the slot
// is free.
module incremental_pid_speed_heading
    import ipsh_pkg::*;
#(
    parameter int MEAS_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ipsh_in_if.sink               i_in,
    ipsh_out_if.source            o_out
);
    t_cmd n_cmd;
    t_sts n_sts;

    ipsh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (n_sts),
        .o_cmd       (n_cmd)
    );

    ipsh_dp #(.W(MEAS_WIDTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_measurement (i_in.measurement),
        .i_gyro_rate   (i_in.gyro_rate),
        .i_cmd         (n_cmd),
        .o_sts         (n_sts),
        .o_drive       (o_out.drive),
        .o_saturated   (o_out.saturated)
    );
endmodule

// File: tb/ipsh_pid_checker.sv
// checker for the incremental pid block: predicts each drive value and compares transfers
module ipsh_pid_checker
    import ipsh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ipsh_in_if                    i_in,
    ipsh_out_if                   i_out,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct {
        logic [15:0] drive;
        logic        saturated;
    } t_drive_result;

    t_drive_result expected_drives[$];

    logic   loop_heading;
    longint target, kp, ki, kd, shrink_k, alpha_w, limit;
    longint filt, filt_d1, filt_d2, last_err, accum;

    function automatic longint clamp24(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint wrap_angle(input longint e);
        longint n;
        if (e > HALF_TURN) begin
            n = (e - HALF_TURN + FULL_TURN - 1) / FULL_TURN;
            e = e - n * FULL_TURN;
        end else if (e < -HALF_TURN) begin
            n = (-HALF_TURN - e + FULL_TURN - 1) / FULL_TURN;
            e = e + n * FULL_TURN;
        end
        return e;
    endfunction

    function automatic longint shrunk_integral(input longint e);
        longint mag;
        longint q;
        mag = (e < 0) ? -e : e;
        q = ((ki * mag) <<< 20) / (shrink_k * mag + (64'sd1 <<< 24));
        return (e < 0) ? -q : q;
    endfunction

    task automatic restore_defaults();
        loop_heading = 1'b0;
        target = 0;
        kp = 512;
        ki = 26;
        kd = 0;
        shrink_k = 2048;
        alpha_w = 77;
        limit = 1000;
        filt = 0;
        filt_d1 = 0;
        filt_d2 = 0;
        last_err = 0;
        accum = 0;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_MODE: loop_heading = d[0];
            REG_SETPOINT: target = longint'($signed(d));
            REG_GAIN_P: kp = longint'(d);
            REG_GAIN_I: ki = longint'(d);
            REG_GAIN_D: kd = longint'(d);
            REG_SHRINK: shrink_k = longint'(d);
            REG_FILTER: alpha_w = longint'(d[8:0]);
            REG_LIMIT: limit = longint'(d[14:0]);
            default: ;
        endcase
    endtask

    task automatic predict_drive(input logic [15:0] meas, input logic [15:0] gyro);
        longint x, g, a, err, dterm, sum, hi;
        t_drive_result r;
        x = longint'($signed(meas));
        g = longint'($signed(gyro));
        a = (alpha_w > 256) ? 256 : alpha_w;
        r.saturated = 1'b0;
        filt = clamp24(filt + ((a * (x * 256 - filt)) >>> 8));
        if (!loop_heading) begin
            err = clamp24(target * 256 - filt);
            dterm = (kd * (filt - 2 * filt_d1 + filt_d2)) >>> 4;
        end else begin
            err = clamp24(wrap_angle(target - x) * 256);
            dterm = -g * kd * 16;
        end
        sum = accum + ((kp * (err - last_err)) >>> 4) + shrunk_integral(err) + dterm;
        hi = limit * 65536;
        if (sum > hi) begin
            sum = hi;
            r.saturated = 1'b1;
        end
        if (sum < -hi) begin
            sum = -hi;
            r.saturated = 1'b1;
        end
        accum = sum;
        if (!loop_heading) begin
            filt_d2 = filt_d1;
            filt_d1 = filt;
        end
        last_err = err;
        r.drive = (sum >= 0) ? 16'(sum >>> 16) : 16'(-((-sum) >>> 16));
        expected_drives.push_back(r);
    endtask

    initial begin
        o_errors = 0;
        restore_defaults();
    end

    assign o_pending = expected_drives.size();

    always @(posedge i_clk) begin
        t_drive_result e;
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            restore_defaults();
            expected_drives.delete();
        end else begin
            if (i_cfg_we) begin
                apply_reg(i_cfg_idx, i_cfg_data);
            end
            if (i_in.valid && i_in.ready) begin
                predict_drive(i_in.measurement, i_in.gyro_rate);
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_drives.size() == 0) begin
                    $display("%0t unexpected transfer: drive %0d saturated %0b", $time,
                             $signed(i_out.drive), i_out.saturated);
                    bad = bad + 1;
                end else begin
                    e = expected_drives.pop_front();
                    if (e.drive !== i_out.drive) begin
                        $display("%0t drive expected %0d got %0d", $time,
                                 $signed(e.drive), $signed(i_out.drive));
                        bad = bad + 1;
                    end
                    if (e.saturated !== i_out.saturated) begin
                        $display("%0t saturated expected %0b got %0b", $time,
                                 e.saturated, i_out.saturated);
                        bad = bad + 1;
                    end
                end
                if (bad != 0) begin
                    o_errors <= o_errors + bad;
                end
            end
        end
    end

endmodule

// File: tb/tb_top.sv
// testbench top: stimulus, register settings, idling phases and verdict
module tb_top;
    import ipsh_pkg::*;

    localparam int MAX_CYCLES = 1500000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    errors;
    int                    pending;
    int                    cycles = 0;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    logic signed [15:0]    cur_target = 0;

    ipsh_in_if  in_ch();
    ipsh_out_if out_ch();

    incremental_pid_speed_heading dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    ipsh_pid_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in(in_ch), .i_out(out_ch),
        .o_errors(errors), .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.measurement = '0;
        in_ch.gyro_rate = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        if (idx == REG_SETPOINT) cur_target = d;
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic [15:0] meas, input logic [15:0] gyro);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.measurement <= meas;
        in_ch.gyro_rate <= gyro;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(4))
            0: return 16'd0;
            1: return 16'hffff;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 1024));
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'(cur_target + $signed(16'($urandom_range(0, 640))) - 16'sd320);
            default: return 16'($urandom_range(0, 8000) - 4000);
        endcase
    endfunction

    task automatic random_settings(input int seg);
        write_reg(REG_MODE, 16'(seg % 3 == 1));
        case ($urandom_range(3))
            0: write_reg(REG_SETPOINT, 16'h8000);
            1: write_reg(REG_SETPOINT, 16'h7fff);
            2: write_reg(REG_SETPOINT, 16'($urandom));
            default: write_reg(REG_SETPOINT, 16'($urandom_range(0, 6000) - 3000));
        endcase
        write_reg(REG_GAIN_P, pick_gain());
        write_reg(REG_GAIN_I, pick_gain());
        write_reg(REG_GAIN_D, pick_gain());
        case ($urandom_range(3))
            0: write_reg(REG_SHRINK, 16'd0);
            1: write_reg(REG_SHRINK, 16'hffff);
            default: write_reg(REG_SHRINK, 16'($urandom));
        endcase
        case ($urandom_range(4))
            0: write_reg(REG_FILTER, 16'd0);
            1: write_reg(REG_FILTER, 16'd256);
            2: write_reg(REG_FILTER, 16'h01ff);
            default: write_reg(REG_FILTER, 16'($urandom_range(0, 511)));
        endcase
        case ($urandom_range(3))
            0: write_reg(REG_LIMIT, 16'd0);
            1: write_reg(REG_LIMIT, 16'h7fff);
            default: write_reg(REG_LIMIT, 16'($urandom_range(0, 32767)));
        endcase
        end_writes();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // speed loop at reset settings, then field extremes
        send_sample(16'd0, 16'd0);
        send_sample(16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h0000);
        send_sample(16'hffff, 16'hffff);
        drain();
        write_reg(REG_GAIN_D, 16'hffff);
        write_reg(REG_FILTER, 16'h01ff);
        write_reg(REG_SHRINK, 16'd0);
        write_reg(REG_LIMIT, 16'h7fff);
        end_writes();
        send_sample(16'h8000, 16'd0);
        send_sample(16'h7fff, 16'd0);
        send_sample(16'h0010, 16'd0);
        drain();
        // heading loop: exact half turns kept, larger errors wrapped
        write_reg(REG_MODE, 16'd1);
        write_reg(REG_SETPOINT, 16'd2880);
        write_reg(REG_GAIN_D, 16'd300);
        write_reg(REG_LIMIT, 16'd0);
        end_writes();
        send_sample(16'd0, 16'h7fff);
        send_sample(16'd5760, 16'h8000);
        send_sample(16'd2879, 16'd0);
        send_sample(16'h8000, 16'd100);
        send_sample(16'h7fff, 16'hff00);
        send_sample(-16'sd2880, 16'd0);
        drain();
        write_reg(REG_SETPOINT, -16'sd2880);
        write_reg(REG_LIMIT, 16'd50);
        end_writes();
        send_sample(16'd0, 16'd0);
        send_sample(16'd2880, 16'd0);
        send_sample(16'd1, 16'd0);
        drain();

        for (int seg = 0; seg < 16; seg++) begin
            case (seg % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 77; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 77; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            random_settings(seg);
            for (int k = 0; k < 102; k++) begin
                send_sample(pick_sample(), 16'($urandom));
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
